// File: sv/wsu_pkg.sv
// Package with the shared types and constants of the WebSocket frame unmasker.
package wsu_pkg;

  // Field of the header byte that carries the FIN bit.
  localparam logic [7:0] FinBit = 8'h80;

  // Low bits of the length byte that carry the payload length.
  localparam logic [7:0] LenMask = 8'h7F;

  // First length code that asks for an extended length field.
  localparam logic [6:0] LenExtended = 7'd126;

  // Parser phases, one-hot.
  typedef enum logic [3:0] {
    PhHeader  = 4'b0001,
    PhLength  = 4'b0010,
    PhMask    = 4'b0100,
    PhPayload = 4'b1000
  } phase_e;

  // One result item as it leaves the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic       frame_fin;
    logic       last_of_frame;
    logic       unsupported_length;
  } result_t;

endpackage

// File: sv/wsu_parser.sv
// Frame parser: phase tracking, mask key storage and payload unmasking.
module wsu_parser
  import wsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output result_t    result_o
);

  phase_e      phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [6:0]  left_q, left_d;
  logic [1:0]  key_idx_q, key_idx_d;
  logic [7:0]  key_q [4];
  logic        key_we;
  logic [6:0]  len;
  logic [6:0]  left_dec;

  assign len      = byte_i[6:0] & LenMask[6:0];
  assign left_dec = left_q - 7'd1;

  // Next-state and result logic for one byte.
  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    left_d    = left_q;
    key_idx_d = key_idx_q;
    key_we    = 1'b0;
    result_o  = '0;
    result_o.frame_fin = fin_q;
    case (phase_q)
      PhHeader: begin
        fin_d   = |(byte_i & FinBit);
        phase_d = PhLength;
      end
      PhLength: begin
        if (len >= LenExtended) begin
          phase_d = PhHeader;
          result_o.valid = 1'b1;
          result_o.unsupported_length = 1'b1;
        end else begin
          left_d    = len;
          key_idx_d = 2'd0;
          phase_d   = PhMask;
        end
      end
      PhMask: begin
        key_we    = 1'b1;
        key_idx_d = key_idx_q + 2'd1;
        if (key_idx_q == 2'd3) begin
          phase_d = (left_q == 7'd0) ? PhHeader : PhPayload;
        end
      end
      PhPayload: begin
        key_idx_d = key_idx_q + 2'd1;
        left_d    = left_dec;
        result_o.valid        = 1'b1;
        result_o.payload_byte = byte_i ^ key_q[key_idx_q];
        if (left_dec == 7'd0) begin
          phase_d = PhHeader;
          result_o.last_of_frame = 1'b1;
        end
      end
      default: begin
        phase_d = PhHeader;
      end
    endcase
  end

  // Control state moves only when a byte is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      fin_q     <= 1'b0;
      left_q    <= 7'd0;
      key_idx_q <= 2'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      fin_q     <= fin_d;
      left_q    <= left_d;
      key_idx_q <= key_idx_d;
    end
  end

  // Mask key bytes are written during the mask phase only.
  always_ff @(posedge clk_i) begin
    if (step_i && key_we) begin
      key_q[key_idx_q] <= byte_i;
    end
  end

endmodule

// File: sv/websocket_frame_unmasker_unit.sv
// Top level of the WebSocket frame unmasker for short-length frames.
//
// The input channel takes one received stream byte per transfer
// (in_valid_i, in_stall_o, in_byte_i). The output channel gives one
// unmasked payload byte per transfer, with the frame's FIN bit, a mark on
// the frame's last byte, and a flag for unsupported extended length codes.
// Header and mask bytes give no output, nor do length bytes with a
// supported code, and neither do zero-length frames.
// Each byte is first captured in an input register, then parsed and
// unmasked combinationally into the output register, from which its
// result is transferred. One byte is taken in every cycle while the
// output side keeps up.
// When the receiver stalls, the output register holds its result and the
// input register holds the next byte; the input side stalls only when
// both are full.
// Reset clears both pipeline registers and returns the parser to the
// header phase; the mask key is loaded from each frame's mask bytes.
module websocket_frame_unmasker_unit
  import wsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       frame_fin_o,
  output logic       last_of_frame_o,
  output logic       unsupported_length_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       step;
  result_t    res;
  result_t    out_q;
  result_t    out_d;

  // The parse stage moves when the output register is free or drains.
  assign advance    = !out_q.valid || !out_stall_i;
  assign step       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  wsu_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (res)
  );

  // A result is only valid when a byte was actually parsed.
  always_comb begin
    out_d       = res;
    out_d.valid = step && res.valid;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o          = out_q.valid;
  assign payload_byte_o       = out_q.payload_byte;
  assign frame_fin_o          = out_q.frame_fin;
  assign last_of_frame_o      = out_q.last_of_frame;
  assign unsupported_length_o = out_q.unsupported_length;

endmodule
